/* src/dtrs_pkg.sv */
`timescale 1ns / 1ps

package dtrs_pkg;

    // Sizes of the splitter.
    localparam int MAX_DELIM_BYTES = 3;
    localparam int MAX_COLUMNS     = 64;
    localparam int NULL_MAX_BYTES  = 8;
    localparam int RES_MAX         = 8;
    localparam int QCAP            = MAX_DELIM_BYTES + 1;

    // Special characters.
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_BSL = 8'd92;

    typedef enum logic [1:0] {
        KIND_DATA      = 2'd0,
        KIND_FIELD_END = 2'd1,
        KIND_REC_END   = 2'd2,
        KIND_ERROR     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TOO_MANY = 2'd1,
        ST_TOO_FEW  = 2'd2,
        ST_BSL_ERR  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CFG_DELIM_BYTES = 3'd0,
        CFG_DELIM_LEN   = 3'd1,
        CFG_NULL_STRING = 3'd2,
        CFG_NULL_LEN    = 3'd3,
        CFG_MAX_FIELDS  = 3'd4,
        CFG_MIN_FIELDS  = 3'd5,
        CFG_NOT_NULL    = 3'd6,
        CFG_SKIP_LINES  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [23:0] delimiter_bytes;
        logic [1:0]  delimiter_length;
        logic [63:0] null_string;
        logic [3:0]  null_length;
        logic [6:0]  max_fields;
        logic [6:0]  min_fields;
        logic [63:0] not_null_mask;
        logic [31:0] skip_lines;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  out_byte;
        logic [5:0]  column_index;
        logic        field_is_null;
        logic [6:0]  field_count;
        t_status     status;
    } t_result;

    typedef struct packed {
        logic [QCAP-1:0][7:0] la;
        logic [2:0]           la_cnt;
        logic                 after_cr;
        logic [5:0]           col;
        logic [6:0]           fields;
        logic [3:0]           rawlen;
        logic                 nmatch;
        logic [31:0]          lines;
        logic                 rec_open;
        logic                 halted;
    } t_state;

    localparam t_state STATE_RESET = '{
        la: '0, la_cnt: 3'd0, after_cr: 1'b0, col: 6'd0, fields: 7'd1,
        rawlen: 4'd0, nmatch: 1'b1, lines: 32'd0, rec_open: 1'b0, halted: 1'b0
    };

    typedef struct packed {
        t_state                   st;
        t_result [RES_MAX-1:0]    res;
        logic [3:0]               n;
    } t_work;

    // Result group handed from the parser to the output serializer.
    typedef struct packed {
        logic                     valid;
        logic [3:0]               count;
        t_result [RES_MAX-1:0]    res;
    } t_group;

    function automatic t_work f_emit(t_work w, t_kind k, logic [7:0] b, logic [5:0] c,
                                     logic nl, logic [6:0] cnt, t_status s);
        if (w.n < 4'(RES_MAX)) begin
            w.res[w.n[2:0]] = '{kind: k, out_byte: b, column_index: c, field_is_null: nl,
                                field_count: cnt, status: s};
            w.n = w.n + 4'd1;
        end
        return w;
    endfunction

    function automatic logic [7:0] f_delim_byte(t_cfg cfg, int k);
        if (k >= MAX_DELIM_BYTES || k >= 3) begin
            return 8'd0;
        end
        return 8'(cfg.delimiter_bytes >> (8 * k));
    endfunction

    function automatic t_work f_pop(t_work w, logic [2:0] n);
        w.st.la     = w.st.la >> {n, 3'b000};
        w.st.la_cnt = w.st.la_cnt - n;
        return w;
    endfunction

    // One byte of field data; tracks the running null-string comparison.
    function automatic t_work f_data_byte(t_work w, t_cfg cfg, logic [7:0] b);
        logic [3:0] p;
        logic [7:0] nb;
        p  = w.st.rawlen;
        w  = f_emit(w, KIND_DATA, b, w.st.col, 1'b0, 7'd0, ST_OK);
        w.st.rec_open = 1'b1;
        nb = 8'(cfg.null_string >> {p[2:0], 3'b000});
        if (p >= 4'(NULL_MAX_BYTES) || b != nb) begin
            w.st.nmatch = 1'b0;
        end
        if (w.st.rawlen < 4'(NULL_MAX_BYTES + 1)) begin
            w.st.rawlen = w.st.rawlen + 4'd1;
        end
        return w;
    endfunction

    function automatic t_work f_end_field(t_work w, t_cfg cfg);
        logic isnull;
        isnull = (cfg.max_fields != 7'd0) && !cfg.not_null_mask[w.st.col] &&
                 (cfg.null_length <= 4'(NULL_MAX_BYTES)) &&
                 (w.st.rawlen == cfg.null_length) && w.st.nmatch;
        w = f_emit(w, KIND_FIELD_END, 8'd0, w.st.col, isnull, 7'd0, ST_OK);
        w.st.rawlen = 4'd0;
        w.st.nmatch = 1'b1;
        return w;
    endfunction

    function automatic t_work f_delim_seen(t_work w, t_cfg cfg);
        logic [6:0] lim;
        lim = (cfg.max_fields > 7'(MAX_COLUMNS)) ? 7'(MAX_COLUMNS) : cfg.max_fields;
        w = f_end_field(w, cfg);
        w.st.rec_open = 1'b1;
        if (w.st.fields < 7'd127) begin
            w.st.fields = w.st.fields + 7'd1;
        end
        if ({1'b0, w.st.col} + 7'd1 < lim) begin
            w.st.col = w.st.col + 6'd1;
        end
        return w;
    endfunction

    function automatic t_work f_record_end(t_work w, t_cfg cfg);
        logic [6:0] cnt;
        t_status    s;
        if (cfg.max_fields == 7'd0 && w.st.fields == 7'd1 && w.st.rawlen == 4'd0) begin
            cnt = 7'd0;
        end else begin
            w   = f_end_field(w, cfg);
            cnt = w.st.fields;
        end
        s = (cnt > cfg.max_fields) ? ST_TOO_MANY :
            ((cnt < cfg.min_fields) ? ST_TOO_FEW : ST_OK);
        w = f_emit(w, KIND_REC_END, 8'd0, 6'd0, 1'b0, cnt, s);
        w.st.col      = 6'd0;
        w.st.fields   = 7'd1;
        w.st.rawlen   = 4'd0;
        w.st.nmatch   = 1'b1;
        w.st.rec_open = 1'b0;
        return w;
    endfunction

    // Resolve held bytes; each pass consumes at least one byte or stops.
    function automatic t_work f_drain(t_work w, t_cfg cfg, logic final_flush);
        logic       done;
        logic [7:0] b;
        logic [2:0] d;
        logic       ok;
        done = 1'b0;
        for (int it = 0; it < QCAP; it++) begin
            if (!done && w.st.la_cnt != 3'd0 && !w.st.halted) begin
                b = w.st.la[0];
                if (b == CH_BSL) begin
                    if (w.st.la_cnt < 3'd2) begin
                        if (!final_flush) begin
                            done = 1'b1;
                        end else begin
                            w = f_pop(w, 3'd1);
                            w = f_data_byte(w, cfg, b);
                        end
                    end else if (w.st.la[1] == f_delim_byte(cfg, 0)) begin
                        w = f_emit(w, KIND_ERROR, 8'd0, 6'd0, 1'b0, 7'd0, ST_BSL_ERR);
                        w.st.halted   = 1'b1;
                        w.st.la       = '0;
                        w.st.la_cnt   = 3'd0;
                        w.st.rec_open = 1'b0;
                        done = 1'b1;
                    end else begin
                        w = f_pop(w, 3'd1);
                        w = f_data_byte(w, cfg, b);
                    end
                end else if (b == CH_CR) begin
                    w = f_pop(w, 3'd1);
                    w = f_record_end(w, cfg);
                    if (w.st.la_cnt != 3'd0) begin
                        if (w.st.la[0] == CH_LF) begin
                            w = f_pop(w, 3'd1);
                        end
                    end else if (!final_flush) begin
                        w.st.after_cr = 1'b1;
                    end
                end else if (b == CH_LF) begin
                    w = f_pop(w, 3'd1);
                    w = f_record_end(w, cfg);
                end else if (b == f_delim_byte(cfg, 0)) begin
                    d  = (cfg.delimiter_length == 2'd0) ? 3'd1 : {1'b0, cfg.delimiter_length};
                    ok = 1'b1;
                    for (int k = 1; k < MAX_DELIM_BYTES; k++) begin
                        if (3'(k) < d && 3'(k) < w.st.la_cnt &&
                            w.st.la[k] != f_delim_byte(cfg, k)) begin
                            ok = 1'b0;
                        end
                    end
                    if (ok && w.st.la_cnt >= d) begin
                        w = f_pop(w, d);
                        w = f_delim_seen(w, cfg);
                    end else if (ok && !final_flush) begin
                        done = 1'b1;
                    end else begin
                        w = f_pop(w, 3'd1);
                        w = f_data_byte(w, cfg, b);
                    end
                end else begin
                    w = f_pop(w, 3'd1);
                    w = f_data_byte(w, cfg, b);
                end
            end
        end
        return w;
    endfunction

    // Full effect of one input transaction on the state and its results.
    function automatic t_work f_step(t_state st, t_cfg cfg, logic [7:0] b, logic eoi);
        t_work w;
        logic  drop;
        w.st  = st;
        w.res = '0;
        w.n   = 4'd0;
        drop  = 1'b0;
        if (!st.halted) begin
            if (eoi) begin
                w.st.after_cr = 1'b0;
                w = f_drain(w, cfg, 1'b1);
                if (w.st.rec_open && !w.st.halted) begin
                    w = f_record_end(w, cfg);
                end
            end else begin
                if (w.st.after_cr) begin
                    w.st.after_cr = 1'b0;
                    drop = (b == CH_LF);
                end
                if (!drop) begin
                    if (w.st.la_cnt == 3'd0 && !w.st.rec_open && w.st.lines < cfg.skip_lines) begin
                        if (b == CH_CR) begin
                            w.st.lines    = w.st.lines + 32'd1;
                            w.st.after_cr = 1'b1;
                        end else if (b == CH_LF) begin
                            w.st.lines = w.st.lines + 32'd1;
                        end
                    end else begin
                        if (w.st.la_cnt < 3'(QCAP)) begin
                            w.st.la[w.st.la_cnt[1:0]] = b;
                            w.st.la_cnt = w.st.la_cnt + 3'd1;
                        end
                        w.st.rec_open = 1'b1;
                        w = f_drain(w, cfg, 1'b0);
                    end
                end
            end
        end
        return w;
    endfunction

endpackage

/* src/delimited_text_record_splitter_top.sv */
`timescale 1ns / 1ps

// Delimited text splitter: bytes enter on the s_axis channel, one per transaction
// (tdata = input byte; tuser = end-of-input flag, which flushes the open record
// and ignores the byte). Results leave on m_axis; tuser gives the result kind
// (data byte, field end, record end, error), tlast marks the final result caused
// by one input transaction.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_wdata while
// the block is idle; each write lands on the next clock edge.
// The first result of an input byte passes the input register and then the
// result buffer before it appears on m_axis. Throughput: one byte per cycle
// while each byte gives at most one result and m_axis_tready is high. A byte
// that gives more results holds the input until the single output channel has
// drained the result buffer, one entry per cycle while m_axis_tready is high.
// Reset (synchronous, active low) restores default configuration, clears all
// parsing state and drops any pending results. When the receiver stalls, the
// result buffer holds and the input side stops after one more byte.
module delimited_text_record_splitter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tuser,   // [0] end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [13:8] column_index,
                                        // [14] field_is_null, [21:15] field_count,
                                        // [23:22] status
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast
);
    import dtrs_pkg::*;

    t_cfg   w_cfg;
    t_group w_grp;
    logic   w_grp_ready;

    // Configuration registers.
    dtrs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (w_cfg)
    );

    // Input register and parsing step.
    dtrs_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .o_grp       (w_grp),
        .i_grp_ready (w_grp_ready)
    );

    // Result buffer and output channel.
    dtrs_out_ser u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp       (w_grp),
        .o_grp_ready (w_grp_ready),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tuser     (m_axis_tuser),
        .o_tlast     (m_axis_tlast)
    );

endmodule

/* src/dtrs_cfg_regs.sv */
`timescale 1ns / 1ps

module dtrs_cfg_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_we,
    input  logic [2:0]       i_index,
    input  logic [63:0]      i_wdata,
    output dtrs_pkg::t_cfg   o_cfg
);
    import dtrs_pkg::*;

    t_cfg r_cfg;

    // Register file with its reset defaults.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delimiter_bytes  <= 24'd44;
            r_cfg.delimiter_length <= 2'd1;
            r_cfg.null_string      <= 64'd0;
            r_cfg.null_length      <= 4'd0;
            r_cfg.max_fields       <= 7'd64;
            r_cfg.min_fields       <= 7'd64;
            r_cfg.not_null_mask    <= 64'd0;
            r_cfg.skip_lines       <= 32'd0;
        end else if (i_we) begin
            case (t_cfg_idx'(i_index))
                CFG_DELIM_BYTES: r_cfg.delimiter_bytes  <= i_wdata[23:0];
                CFG_DELIM_LEN:   r_cfg.delimiter_length <= i_wdata[1:0];
                CFG_NULL_STRING: r_cfg.null_string      <= i_wdata;
                CFG_NULL_LEN:    r_cfg.null_length      <= i_wdata[3:0];
                CFG_MAX_FIELDS:  r_cfg.max_fields       <= i_wdata[6:0];
                CFG_MIN_FIELDS:  r_cfg.min_fields       <= i_wdata[6:0];
                CFG_NOT_NULL:    r_cfg.not_null_mask    <= i_wdata;
                CFG_SKIP_LINES:  r_cfg.skip_lines       <= i_wdata[31:0];
                default:         r_cfg                  <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* src/dtrs_parser.sv */
`timescale 1ns / 1ps

module dtrs_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dtrs_pkg::t_cfg   i_cfg,
    input  logic             i_tvalid,
    output logic             o_tready,
    input  logic [7:0]       i_tdata,
    input  logic             i_tuser,
    output dtrs_pkg::t_group o_grp,
    input  logic             i_grp_ready
);
    import dtrs_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eoi;
    t_state     r_st;
    t_state     n_st;
    t_work      w_work;
    logic       w_consume;

    // The registered item is consumed once the serializer can take its results.
    assign w_consume = r_in_valid && i_grp_ready;
    assign o_tready  = !r_in_valid || i_grp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_tready) begin
            r_in_valid <= i_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tvalid && o_tready) begin
            r_in_byte <= i_tdata;
            r_in_eoi  <= i_tuser;
        end
    end

    // Single pass over the held bytes and the new byte.
    always_comb begin
        w_work = f_step(r_st, i_cfg, r_in_byte, r_in_eoi);
        n_st   = w_consume ? w_work.st : r_st;
        o_grp.valid = w_consume && (w_work.n != 4'd0);
        o_grp.count = w_work.n;
        o_grp.res   = w_work.res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= STATE_RESET;
        end else begin
            r_st <= n_st;
        end
    end

`ifndef ASSERT_OFF
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.halted |=> r_st.halted)
        else $error("halt flag cleared without reset");
    a_la_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.la_cnt <= 3'(MAX_DELIM_BYTES))
        else $error("lookahead holds too many bytes");
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.halted |-> !o_grp.valid)
        else $error("results after error halt");
`endif

endmodule

/* src/dtrs_out_ser.sv */
`timescale 1ns / 1ps

module dtrs_out_ser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dtrs_pkg::t_group i_grp,
    output logic             o_grp_ready,
    output logic             o_tvalid,
    input  logic             i_tready,
    output logic [23:0]      o_tdata,
    output logic [1:0]       o_tuser,
    output logic             o_tlast
);
    import dtrs_pkg::*;

    t_result [RES_MAX-1:0] r_buf;
    logic [3:0]            r_cnt;
    logic                  w_take;

    assign w_take      = (r_cnt != 4'd0) && i_tready;
    assign o_grp_ready = (r_cnt == 4'd0) || ((r_cnt == 4'd1) && i_tready);

    // Result count; a new group loads as the previous one drains.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 4'd0;
        end else if (i_grp.valid) begin
            r_cnt <= i_grp.count;
        end else if (w_take) begin
            r_cnt <= r_cnt - 4'd1;
        end
    end

    // Results shift toward the head entry as transactions complete.
    always_ff @(posedge i_clk) begin
        if (i_grp.valid) begin
            r_buf <= i_grp.res;
        end else if (w_take) begin
            r_buf <= {t_result'('0), r_buf[RES_MAX-1:1]};
        end
    end

    assign o_tvalid = (r_cnt != 4'd0);
    assign o_tlast  = (r_cnt == 4'd1);
    assign o_tuser  = r_buf[0].kind;
    assign o_tdata  = {r_buf[0].status, r_buf[0].field_count, r_buf[0].field_is_null,
                       r_buf[0].column_index, r_buf[0].out_byte};

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_grp.valid |-> o_grp_ready)
        else $error("result group loaded over pending results");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 4'(RES_MAX))
        else $error("result count out of range");
    a_group_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_grp.valid |-> (i_grp.count != 4'd0 && i_grp.count <= 4'(RES_MAX)))
        else $error("bad result group size");
`endif

endmodule
